// File: src/itad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itad_pkg
// Shared widths, character codes, the job record and the back-end states of
// the integer to ASCII digits converter.
// ----------------------------------------------------------------------------
package itad_pkg;

  localparam int NUM_W      = 64;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int DEC_DIGITS = 20;
  localparam int HEX_DIGITS = NUM_W / DIGIT_W;
  localparam int BCD_W      = DEC_DIGITS * DIGIT_W;
  localparam int IDX_W      = $clog2(DEC_DIGITS);

  // Binary to BCD conversion consumes this many input bits per cycle.
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = NUM_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(STEPS);

  localparam int DEFAULT_QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X          = 8'h78;
  localparam logic [CHAR_W-1:0] CH_ALPHA_BASE = 8'h37;  // 'A' minus ten

  // One classified conversion job as it travels through the queue.
  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic             hex_mode;
    logic [IDX_W-1:0] hex_top;  // index of the most significant nonzero nibble
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_PREFIX0,
    ST_PREFIXX,
    ST_DIGITS
  } back_state_t;

  // Digit value to uppercase ASCII glyph.
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] w;
    w = CHAR_W'(d);
    return (d < DIGIT_W'(10)) ? (CH_ZERO + w) : (CH_ALPHA_BASE + w);
  endfunction

endpackage

// File: src/itad_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itad_if
// Valid/ready channels for numbers going in and characters coming out.
// ----------------------------------------------------------------------------
interface itad_in_if;
  logic                       valid;
  logic                       ready;
  logic [itad_pkg::NUM_W-1:0] number;
  logic                       hex_mode;

  modport source (output valid, output number, output hex_mode, input ready);
  modport sink   (input valid, input number, input hex_mode, output ready);
endinterface

interface itad_out_if;
  logic                        valid;
  logic                        ready;
  logic [itad_pkg::CHAR_W-1:0] ascii_char;
  logic                        last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

// File: src/itad_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itad_front
// Accepts numbers, classifies them and registers the job toward the queue.
// ----------------------------------------------------------------------------
module itad_front (
  input  logic            clk,
  input  logic            rst_n,
  itad_in_if.sink         in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output itad_pkg::job_t  push_job
);

  logic                            full_r;
  logic                            full_nxt;
  itad_pkg::job_t                  job_r;
  logic [itad_pkg::IDX_W-1:0]      hex_top;
  logic                            take;

  // The highest nonzero nibble sets how many hex digits are printed.
  always_comb begin
    hex_top = '0;
    for (int d = 0; d < itad_pkg::HEX_DIGITS; d++) begin
      if (in_ch.number[d*itad_pkg::DIGIT_W +: itad_pkg::DIGIT_W] != '0) begin
        hex_top = itad_pkg::IDX_W'(d);
      end
    end
  end

  assign in_ch.ready = !full_r || push_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign push_valid  = full_r;
  assign push_job    = job_r;

  always_comb begin
    full_nxt = full_r;
    if (take) begin
      full_nxt = 1'b1;
    end else if (push_ready) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r.number   <= in_ch.number;
      job_r.hex_mode <= in_ch.hex_mode;
      job_r.hex_top  <= hex_top;
    end
  end

endmodule

// File: src/itad_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itad_queue
// Short first-in first-out queue of jobs between the front and the back end.
// ----------------------------------------------------------------------------
module itad_queue #(
  parameter int DEPTH = itad_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  itad_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output itad_pkg::job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  itad_pkg::job_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: src/itad_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itad_back
// Converts one job to digits and sends them out one character per transfer.
// ----------------------------------------------------------------------------
module itad_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  itad_pkg::job_t pop_job,
  itad_out_if.source     out_ch
);

  itad_pkg::back_state_t             state_r;
  itad_pkg::back_state_t             state_nxt;
  logic [itad_pkg::BCD_W-1:0]        bcd_r;
  logic [itad_pkg::BCD_W-1:0]        bcd_nxt;
  logic [itad_pkg::NUM_W-1:0]        bin_r;
  logic [itad_pkg::NUM_W-1:0]        bin_nxt;
  logic [itad_pkg::STEP_W-1:0]       step_r;
  logic [itad_pkg::STEP_W-1:0]       step_nxt;
  logic [itad_pkg::IDX_W-1:0]        idx_r;
  logic [itad_pkg::IDX_W-1:0]        idx_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [itad_pkg::CHAR_W-1:0]       out_char_r;
  logic [itad_pkg::CHAR_W-1:0]       out_char_nxt;
  logic                              out_last_r;
  logic                              out_last_nxt;
  logic                              adv;
  logic [itad_pkg::IDX_W-1:0]        dec_top;
  logic [itad_pkg::DIGIT_W-1:0]      cur_digit;

  // Shift-and-add-three, several input bits per call, most significant first.
  function automatic logic [itad_pkg::BCD_W-1:0] dabble(
    input logic [itad_pkg::BCD_W-1:0]         b,
    input logic [itad_pkg::BITS_PER_STEP-1:0] bits
  );
    logic [itad_pkg::BCD_W-1:0] acc;
    acc = b;
    for (int s = itad_pkg::BITS_PER_STEP - 1; s >= 0; s--) begin
      for (int d = 0; d < itad_pkg::DEC_DIGITS; d++) begin
        if (acc[d*itad_pkg::DIGIT_W +: itad_pkg::DIGIT_W] >= itad_pkg::DIGIT_W'(5)) begin
          acc[d*itad_pkg::DIGIT_W +: itad_pkg::DIGIT_W] =
            acc[d*itad_pkg::DIGIT_W +: itad_pkg::DIGIT_W] + itad_pkg::DIGIT_W'(3);
        end
      end
      acc = {acc[itad_pkg::BCD_W-2:0], bits[s]};
    end
    return acc;
  endfunction

  // Most significant nonzero decimal digit; zero leaves index 0.
  always_comb begin
    dec_top = '0;
    for (int d = 0; d < itad_pkg::DEC_DIGITS; d++) begin
      if (bcd_r[d*itad_pkg::DIGIT_W +: itad_pkg::DIGIT_W] != '0) begin
        dec_top = itad_pkg::IDX_W'(d);
      end
    end
  end

  assign cur_digit = bcd_r[idx_r*itad_pkg::DIGIT_W +: itad_pkg::DIGIT_W];
  assign adv       = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ascii_char = out_char_r;
  assign out_ch.last_char  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    bcd_nxt       = bcd_r;
    bin_nxt       = bin_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    pop_ready     = 1'b0;
    unique case (state_r)
      itad_pkg::ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_job.hex_mode) begin
            bcd_nxt   = itad_pkg::BCD_W'(pop_job.number);
            idx_nxt   = pop_job.hex_top;
            state_nxt = itad_pkg::ST_PREFIX0;
          end else begin
            bcd_nxt   = '0;
            bin_nxt   = pop_job.number;
            step_nxt  = '0;
            state_nxt = itad_pkg::ST_CONV;
          end
        end
      end
      itad_pkg::ST_CONV: begin
        bcd_nxt  = dabble(bcd_r,
                          bin_r[itad_pkg::NUM_W-1 -: itad_pkg::BITS_PER_STEP]);
        bin_nxt  = bin_r << itad_pkg::BITS_PER_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == itad_pkg::STEP_W'(itad_pkg::STEPS - 1)) begin
          state_nxt = itad_pkg::ST_COUNT;
        end
      end
      itad_pkg::ST_COUNT: begin
        idx_nxt   = dec_top;
        state_nxt = itad_pkg::ST_DIGITS;
      end
      itad_pkg::ST_PREFIX0: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itad_pkg::CH_ZERO;
          out_last_nxt  = 1'b0;
          state_nxt     = itad_pkg::ST_PREFIXX;
        end
      end
      itad_pkg::ST_PREFIXX: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itad_pkg::CH_X;
          out_last_nxt  = 1'b0;
          state_nxt     = itad_pkg::ST_DIGITS;
        end
      end
      itad_pkg::ST_DIGITS: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itad_pkg::glyph(cur_digit);
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = itad_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = itad_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itad_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r      <= bcd_nxt;
    bin_r      <= bin_nxt;
    step_r     <= step_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // The final digit of a number always carries the end marker.
  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itad_pkg::ST_DIGITS && adv && idx_r == '0)
      |=> (out_valid_r && out_last_r))
    else $error("final digit sent without end marker");

  // The prefix x is never the end of a number.
  a_prefix_x: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itad_pkg::ST_PREFIXX && adv)
      |=> (out_valid_r && out_char_r == itad_pkg::CH_X && !out_last_r))
    else $error("prefix character sent wrongly");

  // Conversion runs its full step count and then sizes the digit string.
  a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itad_pkg::ST_CONV && step_r == itad_pkg::STEP_W'(itad_pkg::STEPS - 1))
      |=> (state_r == itad_pkg::ST_COUNT))
    else $error("conversion did not finish on its last step");

  // A decimal digit string never starts beyond the twentieth digit.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itad_pkg::ST_DIGITS)
      |-> (idx_r <= itad_pkg::IDX_W'(itad_pkg::DEC_DIGITS - 1)))
    else $error("digit index out of range");

endmodule

// File: src/integer_to_ascii_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// Turns an unsigned 64-bit value into decimal or 0x-prefixed hex ASCII text.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                     One transfer carries
//  in_ch     sink       number[63:0], hex_mode      one value to print
//  out_ch    source     ascii_char[7:0], last_char  one character, MSD first
//
// A decimal value passes through the back end in order: it is taken from the
// queue, converted by shift-and-add-three BCD conversion, four input bits
// per cycle, and its leading digit is found before its first digit goes into
// the output register. Then one character leaves per cycle while out_ch is
// not stalled; a hex value skips the conversion and first sends its 0x prefix.
// Reset is synchronous and active low; it empties the queue and the output.
// The front end and queue keep taking values, until both are full, while the
// back end waits on a stalled out_ch, and the output register holds its character until taken.
//
// Structure: the front end registers each value and notes its leading hex
// nibble, a short queue decouples it from the back end, and the back end
// converts and streams the characters through its output register. Hex
// values skip the BCD conversion since their digits are the nibbles.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits #(
  parameter int QUEUE_DEPTH = itad_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  itad_in_if.sink    in_ch,
  itad_out_if.source out_ch
);

  logic           push_valid;
  logic           push_ready;
  itad_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  itad_pkg::job_t pop_job;

  // Classifies each incoming value and holds it for the queue.
  itad_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // Lets the front end run ahead while characters drain.
  itad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Converts one value at a time and streams its characters.
  itad_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule

// File: verif/integer_to_ascii_digits_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_tb
// Self-checking bench for the integer to ASCII digits converter. Values go
// in over the number channel, and every character that comes out is checked
// against text predicted in the bench. A short directed list comes first,
// then random values whose magnitudes spread over every digit count. The
// random part runs under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_tb;

  localparam time CLK_PERIOD  = 20ns;
  localparam int  RESET_TICKS = 7;
  // The drain wait outlasts the longest decimal value in the back end, so it
  // leaves ample room for a stray character to show up after the drain.
  localparam int  DRAIN_TICKS = 80;

  localparam logic [itad_pkg::CHAR_W-1:0] ASCII_ZERO = "0";
  localparam logic [itad_pkg::CHAR_W-1:0] ASCII_X    = "x";
  localparam logic [itad_pkg::CHAR_W-1:0] ASCII_A    = "A";

  // One value waiting to be offered on the number channel.
  typedef struct {
    logic [itad_pkg::NUM_W-1:0] number;
    logic                       hex_mode;
  } print_job_t;

  // One character that the converter is expected to send.
  typedef struct {
    logic [itad_pkg::CHAR_W-1:0] ascii_char;
    logic                        last_char;
  } text_char_t;

  logic clk;
  logic rst_n;

  itad_in_if  in_ch ();
  itad_out_if out_ch ();

  integer_to_ascii_digits u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  print_job_t pending_jobs[$];   // values not yet offered to the converter
  text_char_t expected_text[$];  // characters still owed, oldest first
  print_job_t next_job;

  int  sender_idle_pct;  // chance per cycle that no new value is offered
  int  recv_stall_pct;   // chance per cycle that ready is held low
  int  error_count = 0;
  logic number_taken;    // a transfer on the number channel at the last edge

  // --------------------------------------------------------------------------
  // Clock and reset. Reset is synchronous, so it is released at a falling
  // edge, once rising edges have seen it low.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (RESET_TICKS) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Text predictor. Digits are peeled off least significant first, then sent
  // most significant first. Zero still yields one digit, and in hex mode the
  // "0x" prefix is never the last character since a digit always follows.
  // --------------------------------------------------------------------------
  function automatic logic [itad_pkg::CHAR_W-1:0] digit_char(
    input logic [itad_pkg::DIGIT_W-1:0] d
  );
    if (d < 4'd10) begin
      return ASCII_ZERO + itad_pkg::CHAR_W'(d);
    end
    return ASCII_A + itad_pkg::CHAR_W'(d - 4'd10);
  endfunction

  function automatic void predict_text(input logic [itad_pkg::NUM_W-1:0] number,
                                       input logic hex_mode);
    logic [itad_pkg::CHAR_W-1:0] digits[$];
    logic [itad_pkg::NUM_W-1:0]  rest;
    text_char_t                  ch;
    rest = number;
    do begin
      if (hex_mode) begin
        digits.push_back(digit_char(rest[itad_pkg::DIGIT_W-1:0]));
        rest = rest >> itad_pkg::DIGIT_W;
      end else begin
        digits.push_back(digit_char(itad_pkg::DIGIT_W'(rest % 64'd10)));
        rest = rest / 64'd10;
      end
    end while (rest != '0);
    if (hex_mode) begin
      ch.ascii_char = ASCII_ZERO;
      ch.last_char  = 1'b0;
      expected_text.push_back(ch);
      ch.ascii_char = ASCII_X;
      expected_text.push_back(ch);
    end
    while (digits.size() != 0) begin
      ch.ascii_char = digits.pop_back();
      ch.last_char  = (digits.size() == 0);
      expected_text.push_back(ch);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver. Inputs change on the falling edge only. A value stays on the
  // channel until a transfer has taken it; after that the next one may follow
  // at once, or a random gap is inserted. Ready on the character channel is
  // redrawn every cycle against the current stall rate.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || number_taken) begin
        if (pending_jobs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_job        = pending_jobs.pop_front();
          in_ch.number   <= next_job.number;
          in_ch.hex_mode <= next_job.hex_mode;
          in_ch.valid    <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Both channels are sampled on the rising edge. An accepted value
  // appends its predicted text; each character transfer is matched against
  // the oldest character still owed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      number_taken <= 1'b0;
    end else begin
      number_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_text(in_ch.number, in_ch.hex_mode);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character %h, last_char %b", out_ch.ascii_char,
                 out_ch.last_char);
          error_count++;
        end else begin
          text_char_t want;
          want = expected_text.pop_front();
          if (out_ch.ascii_char !== want.ascii_char) begin
            $error("ascii_char: expected %h, got %h", want.ascii_char, out_ch.ascii_char);
            error_count++;
          end
          if (out_ch.last_char !== want.last_char) begin
            $error("last_char: expected %b, got %b", want.last_char, out_ch.last_char);
            error_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic add_job(input logic [itad_pkg::NUM_W-1:0] number, input logic hex_mode);
    print_job_t job;
    job.number   = number;
    job.hex_mode = hex_mode;
    pending_jobs.push_back(job);
  endtask

  // Random values: mostly a random bit length so that short and long texts
  // both show up often, sometimes a neighbor of a power of ten where the
  // decimal digit count steps, and sometimes all 64 bits at random.
  function automatic logic [itad_pkg::NUM_W-1:0] random_number();
    logic [itad_pkg::NUM_W-1:0] r;
    logic [itad_pkg::NUM_W-1:0] pow10;
    int                         width;
    int                         pick;
    r    = {$urandom(), $urandom()};
    pick = $urandom_range(7);
    if (pick == 0) begin
      pow10 = 64'd1;
      repeat ($urandom_range(19)) pow10 = pow10 * 64'd10;
      return pow10 - itad_pkg::NUM_W'($urandom_range(1));
    end else if (pick == 1) begin
      return r;
    end
    width = $urandom_range(64, 1);
    if (width < itad_pkg::NUM_W) begin
      r = r & ((64'd1 << width) - 64'd1);
    end
    return r;
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (count) add_job(random_number(), 1'($urandom_range(1)));
    // Wait until the last value of this phase has been taken.
    while (pending_jobs.size() != 0 || in_ch.valid) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    sender_idle_pct = 0;
    recv_stall_pct  = 0;

    // Directed values: zero in both modes, single digits, the step from one
    // to two digits, the largest values, the point where decimal text grows
    // to twenty digits, and sign-extended 32-bit values.
    add_job(64'd0, 1'b0);
    add_job(64'd0, 1'b1);
    add_job(64'd1, 1'b0);
    add_job(64'd9, 1'b0);
    add_job(64'd10, 1'b0);
    add_job(64'd15, 1'b1);
    add_job(64'd16, 1'b1);
    add_job(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_job(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    add_job(64'd9999999999999999999, 1'b0);
    add_job(64'd10000000000000000000, 1'b0);
    add_job(64'h8000_0000_0000_0000, 1'b0);
    add_job(64'h8000_0000_0000_0000, 1'b1);
    add_job(64'h0123_4567_89AB_CDEF, 1'b1);
    add_job(64'hFEDC_BA98_7654_3210, 1'b1);
    add_job(64'hFFFF_FFFF_8000_0000, 1'b0);
    add_job(64'hFFFF_FFFF_8000_0000, 1'b1);
    add_job(64'h0000_0000_7FFF_FFFF, 1'b0);
    add_job(64'd1234567890, 1'b0);
    add_job(64'h0000_0000_0000_00A0, 1'b1);
    add_job(64'h5555_5555_5555_5555, 1'b0);
    add_job(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // The directed list drains with no idling, followed by the random phases:
    // free running, a mostly idle sender, a mostly stalled receiver, and a
    // light mix of both.
    run_phase(0, 0, 58);
    run_phase(78, 0, 57);
    run_phase(0, 78, 57);
    run_phase(20, 20, 58);

    // Let every owed character arrive, then give the converter time to send
    // anything it should not.
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);

    if (error_count == 0) begin
      $display("[integer_to_ascii_digits] OK");
    end else begin
      $display("[integer_to_ascii_digits] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake; far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("[integer_to_ascii_digits] ERROR");
    $finish;
  end

endmodule
